// ----- sv/vdsd_pkg.sv -----
// shared types and codes for the vector difference, sort and dot unit
// no dependencies; every other file uses these by scoped name
package vdsd_pkg;

  // signed q9.8 difference b - a, one bit wider than the operands
  typedef logic signed [16:0] diff_t;

  // signed q20.16 dot product accumulator
  typedef logic signed [35:0] acc_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DIFF   = 2'd0,
    KIND_SORTED = 2'd1,
    KIND_DOT    = 2'd2
  } kind_t;

  // input transaction payload
  typedef struct packed {
    logic signed [15:0] a_value;
    logic signed [15:0] b_value;
    logic               last_item;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    kind_t              kind;
    logic signed [35:0] value;
    logic [3:0]         position;
    logic               overflow;
    logic               run_end;
  } out_item_t;

  // commands broadcast to every sort cell
  typedef struct packed {
    logic insert;
    logic drain;
    logic clear;
  } cell_ctrl_t;

  // saturation bounds of the accumulator
  localparam acc_t ACC_MAX = {1'b0, {35{1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {35{1'b0}}};

endpackage

// ----- sv/vdsd_cell.sv -----
// one cell of the descending insertion chain: holds one stored difference
// depends on vdsd_pkg
module vdsd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  vdsd_pkg::cell_ctrl_t ctrl,
  input  vdsd_pkg::diff_t     din,
  input  logic                left_shift,
  input  vdsd_pkg::diff_t     left_value,
  input  logic                left_valid,
  input  vdsd_pkg::diff_t     right_value,
  input  logic                right_valid,
  output logic                shift,
  output vdsd_pkg::diff_t     value,
  output logic                valid
);

  vdsd_pkg::diff_t value_r, value_nxt;
  logic            valid_r, valid_nxt;

  // an empty cell or a smaller value moves down for the new entry; ties stay
  assign shift = !valid_r || (value_r < din);

  // insert, drain toward the head, or clear
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.insert && shift) begin
      if (left_shift) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else begin
        value_nxt = din;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.drain) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// ----- sv/vdsd_dot_acc.sv -----
// dot product unit: registered 16x16 product, then saturating accumulate
// depends on vdsd_pkg
module vdsd_dot_acc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mul_en,
  input  logic signed [15:0] a_value,
  input  logic signed [15:0] b_value,
  input  logic               clear,
  output vdsd_pkg::acc_t     acc
);

  logic signed [31:0] prod_r, prod_nxt;
  logic               prod_vld_r;
  vdsd_pkg::acc_t     acc_r, acc_nxt;
  logic signed [36:0] sum;

  assign prod_nxt = a_value * b_value;
  assign sum      = 37'(acc_r) + 37'(prod_r);

  // saturate to the signed 36-bit range
  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      if (!sum[36] && sum[35]) begin
        acc_nxt = vdsd_pkg::ACC_MAX;
      end else if (sum[36] && !sum[35]) begin
        acc_nxt = vdsd_pkg::ACC_MIN;
      end else begin
        acc_nxt = sum[35:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= mul_en && !clear;
      acc_r      <= acc_nxt;
    end
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ----- sv/vector_difference_sort_and_dot_unit.sv -----
// top level: pair differences, descending sort in a cell chain, dot product
// depends on vdsd_pkg, vdsd_cell, vdsd_dot_acc
//
//  channel  ports                         payload      direction
//  in       in_valid  in_ready  in_data   in_item_t    pair (a, b, last)
//  out      out_valid out_ready out_data  out_item_t   diff / sorted / dot
//
// a pair's difference is inserted into the sorted chain and loaded into the
// output register when accepted; with the chain full it is dropped and flags overflow.
// after the last pair the chain drains one sorted entry per cycle while the
// output is free, then emits the dot product; the next pair is taken after.
// synchronous active-low reset empties the chain and clears all counters.
// a stalled output holds the chain and blocks new pairs until taken.
module vector_difference_sort_and_dot_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vdsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vdsd_pkg::out_item_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DOT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rank_r, rank_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  vdsd_pkg::out_item_t out_data_r, out_data_nxt;

  logic                out_free;
  logic                accept;
  logic                room;
  vdsd_pkg::diff_t     diff;
  vdsd_pkg::cell_ctrl_t ctrl;
  vdsd_pkg::acc_t      acc;

  logic                  cell_shift [DEPTH];
  vdsd_pkg::diff_t       cell_value [DEPTH];
  logic                  cell_valid [DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_LOAD) && out_free;
  assign accept   = in_valid && in_ready;
  assign room     = count_r < CW'(DEPTH);
  assign diff     = vdsd_pkg::diff_t'(in_data.b_value) - vdsd_pkg::diff_t'(in_data.a_value);

  // sort chain: each cell sees its left neighbor on insert, right on drain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            l_shift, r_valid, l_valid;
    vdsd_pkg::diff_t l_value, r_value;
    if (i == 0) begin : g_head
      assign l_shift = 1'b0;
      assign l_value = '0;
      assign l_valid = 1'b0;
    end else begin : g_body
      assign l_shift = cell_shift[i-1];
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end
    vdsd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .din         (diff),
      .left_shift  (l_shift),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .shift       (cell_shift[i]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  // dot product accumulator
  vdsd_dot_acc u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .mul_en  (accept && room),
    .a_value (in_data.a_value),
    .b_value (in_data.b_value),
    .clear   (ctrl.clear),
    .acc     (acc)
  );

  // sequencer and output register next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rank_nxt      = rank_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            ctrl.insert           = 1'b1;
            count_nxt             = count_r + CW'(1);
            out_valid_nxt         = 1'b1;
            out_data_nxt.kind     = vdsd_pkg::KIND_DIFF;
            out_data_nxt.value    = 36'(diff);
            out_data_nxt.position = 4'(count_r);
            out_data_nxt.overflow = ovf_r;
            out_data_nxt.run_end  = 1'b0;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            state_nxt = ST_RUN;
            rank_nxt  = '0;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          ctrl.drain            = 1'b1;
          out_valid_nxt         = 1'b1;
          out_data_nxt.kind     = vdsd_pkg::KIND_SORTED;
          out_data_nxt.value    = 36'(cell_value[0]);
          out_data_nxt.position = 4'(rank_r);
          out_data_nxt.overflow = ovf_r;
          out_data_nxt.run_end  = 1'b0;
          if (rank_r == count_r - CW'(1)) begin
            state_nxt = ST_DOT;
          end
          rank_nxt = rank_r + CW'(1);
        end
      end
      ST_DOT: begin
        if (out_free) begin
          ctrl.clear            = 1'b1;
          out_valid_nxt         = 1'b1;
          out_data_nxt.kind     = vdsd_pkg::KIND_DOT;
          out_data_nxt.value    = acc;
          out_data_nxt.position = '0;
          out_data_nxt.overflow = ovf_r;
          out_data_nxt.run_end  = 1'b1;
          count_nxt             = '0;
          rank_nxt              = '0;
          ovf_nxt               = 1'b0;
          state_nxt             = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      rank_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rank_r      <= rank_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
